// ===== sv/voxmk_pkg.sv =====
// Shared constants, types and helpers for the point cloud voxel marker.
package voxmk_pkg;

	localparam int GRID_X = 128;
	localparam int GRID_Y = 128;
	localparam int GRID_Z = 64;
	localparam int CELL_COUNT = GRID_X * GRID_Y * GRID_Z;
	localparam int ADDR_W = $clog2(CELL_COUNT);

	localparam int COORD_W = 32;
	localparam int PROD_W = 2 * COORD_W;
	localparam int RND_W = COORD_W + 1;
	localparam int CELL_X_W = 7;
	localparam int CELL_Y_W = 7;
	localparam int CELL_Z_W = 6;

	localparam int CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] REG_X_MIN = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_X_MAX = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_Y_MIN = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_Y_MAX = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_Z_MIN = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_Z_MAX = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_INV_RES = 3'd6;

	localparam logic [COORD_W-1:0] INV_RES_RESET = 32'd65536;

	localparam logic REQ_MARK = 1'b0;
	localparam logic REQ_READ = 1'b1;

	// Load enables of the pipeline registers, one per stage.
	typedef struct packed {
		logic s1;
		logic s2;
		logic s3;
		logic s4;
	} pipe_en_t;

	// Limits a rounded index to the last cell of its axis.
	function automatic logic [RND_W-1:0] sat_idx(input logic [RND_W-1:0] rnd,
		input logic [RND_W-1:0] last);
		sat_idx = (rnd > last) ? last : rnd;
	endfunction

	// Linear cell address, x fastest, then y, then z.
	function automatic logic [ADDR_W-1:0] cell_addr(input logic [ADDR_W-1:0] x,
		input logic [ADDR_W-1:0] y, input logic [ADDR_W-1:0] z);
		cell_addr = (z * ADDR_W'(GRID_Y) + y) * ADDR_W'(GRID_X) + x;
	endfunction

endpackage

// ===== sv/point_cloud_voxel_marker.sv =====
// An item is accepted into stage 1 and its result is offered from the stage 4 registers.
// Throughput: one item per cycle, unless the output stalls or the clearing pass runs.
// A mark and a later read of the same cell see each other, as both use the RAM in stage 3.
// Reset clears control and bounds and presets the reciprocal; a clearing pass then writes
// zero to all 1,048,576 cells, one per cycle, and no item is accepted until it is done.
module point_cloud_voxel_marker (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [voxmk_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [voxmk_pkg::COORD_W-1:0]       cfg_data,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic                                req_type,
	input  logic [voxmk_pkg::COORD_W-1:0]       point_x,
	input  logic [voxmk_pkg::COORD_W-1:0]       point_y,
	input  logic [voxmk_pkg::COORD_W-1:0]       point_z,
	input  logic [voxmk_pkg::CELL_X_W-1:0]      read_x,
	input  logic [voxmk_pkg::CELL_Y_W-1:0]      read_y,
	input  logic [voxmk_pkg::CELL_Z_W-1:0]      read_z,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic                                in_grid,
	output logic [voxmk_pkg::CELL_X_W-1:0]      cell_x,
	output logic [voxmk_pkg::CELL_Y_W-1:0]      cell_y,
	output logic [voxmk_pkg::CELL_Z_W-1:0]      cell_z,
	output logic                                occupied
);
	import voxmk_pkg::*;

	logic [COORD_W-1:0] x_min_q, x_max_q, y_min_q, y_max_q, z_min_q, z_max_q, inv_q;

	logic              clr_q;
	logic [ADDR_W-1:0] clr_addr_q;

	pipe_en_t en;
	logic     accept;

	logic                v_s1, v_s2, v_s3, v_s4;
	logic                req_s1, req_s2, req_s3, req_s4;
	logic [COORD_W-1:0]  px_s1, py_s1, pz_s1;
	logic [CELL_X_W-1:0] rx_s1, rx_s2, rx_s3;
	logic [CELL_Y_W-1:0] ry_s1, ry_s2, ry_s3;
	logic [CELL_Z_W-1:0] rz_s1, rz_s2, rz_s3;
	logic                hit_s2, hit_s3, hit_s4;
	logic                rd_ok_s4;
	logic [CELL_X_W-1:0] cx_s4;
	logic [CELL_Y_W-1:0] cy_s4;
	logic [CELL_Z_W-1:0] cz_s4;

	logic             in_x, in_y, in_z;
	logic [RND_W-1:0] rnd_x_s3, rnd_y_s3, rnd_z_s3;
	logic [RND_W-1:0] idx_x, idx_y, idx_z;
	logic             rd_ok;
	logic [ADDR_W-1:0] mark_addr, read_addr;

	logic              ram_we, ram_re, ram_wdata, ram_rdata;
	logic [ADDR_W-1:0] ram_waddr;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_min_q <= '0;
			x_max_q <= '0;
			y_min_q <= '0;
			y_max_q <= '0;
			z_min_q <= '0;
			z_max_q <= '0;
			inv_q <= INV_RES_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_X_MIN: x_min_q <= cfg_data;
				REG_X_MAX: x_max_q <= cfg_data;
				REG_Y_MIN: y_min_q <= cfg_data;
				REG_Y_MAX: y_max_q <= cfg_data;
				REG_Z_MIN: z_min_q <= cfg_data;
				REG_Z_MAX: z_max_q <= cfg_data;
				REG_INV_RES: inv_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= 1'b1;
			clr_addr_q <= '0;
		end else if (clr_q) begin
			clr_addr_q <= clr_addr_q + 1'b1;
			if (clr_addr_q == ADDR_W'(CELL_COUNT - 1)) begin
				clr_q <= 1'b0;
			end
		end
	end

	// Each stage loads when it is empty or when the stage after it moves on.
	always_comb begin
		en.s4 = !v_s4 || !out_stall;
		en.s3 = !v_s3 || en.s4;
		en.s2 = !v_s2 || en.s3;
		en.s1 = !v_s1 || en.s2;
	end
	assign in_stall = clr_q || !en.s1;
	assign accept = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (en.s1) begin
				v_s1 <= accept;
			end
			if (en.s2) begin
				v_s2 <= v_s1;
			end
			if (en.s3) begin
				v_s3 <= v_s2;
			end
			if (en.s4) begin
				v_s4 <= v_s3;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en.s1) begin
			req_s1 <= req_type;
			px_s1 <= point_x;
			py_s1 <= point_y;
			pz_s1 <= point_z;
			rx_s1 <= read_x;
			ry_s1 <= read_y;
			rz_s1 <= read_z;
		end
		if (en.s2) begin
			req_s2 <= req_s1;
			hit_s2 <= (req_s1 == REQ_MARK) && in_x && in_y && in_z;
			rx_s2 <= rx_s1;
			ry_s2 <= ry_s1;
			rz_s2 <= rz_s1;
		end
		if (en.s3) begin
			req_s3 <= req_s2;
			hit_s3 <= hit_s2;
			rx_s3 <= rx_s2;
			ry_s3 <= ry_s2;
			rz_s3 <= rz_s2;
		end
	end

	voxmk_axis u_axis_x (
		.clk    (clk),
		.en     (en),
		.p_s1   (px_s1),
		.lo     (x_min_q),
		.hi     (x_max_q),
		.inv    (inv_q),
		.in_box (in_x),
		.rnd_s3 (rnd_x_s3)
	);

	voxmk_axis u_axis_y (
		.clk    (clk),
		.en     (en),
		.p_s1   (py_s1),
		.lo     (y_min_q),
		.hi     (y_max_q),
		.inv    (inv_q),
		.in_box (in_y),
		.rnd_s3 (rnd_y_s3)
	);

	voxmk_axis u_axis_z (
		.clk    (clk),
		.en     (en),
		.p_s1   (pz_s1),
		.lo     (z_min_q),
		.hi     (z_max_q),
		.inv    (inv_q),
		.in_box (in_z),
		.rnd_s3 (rnd_z_s3)
	);

	assign idx_x = sat_idx(rnd_x_s3, RND_W'(GRID_X - 1));
	assign idx_y = sat_idx(rnd_y_s3, RND_W'(GRID_Y - 1));
	assign idx_z = sat_idx(rnd_z_s3, RND_W'(GRID_Z - 1));

	assign mark_addr = cell_addr(ADDR_W'(idx_x), ADDR_W'(idx_y), ADDR_W'(idx_z));
	assign read_addr = cell_addr(ADDR_W'(rx_s3), ADDR_W'(ry_s3), ADDR_W'(rz_s3));
	assign rd_ok = (RND_W'(rx_s3) < RND_W'(GRID_X)) && (RND_W'(ry_s3) < RND_W'(GRID_Y)) &&
		(RND_W'(rz_s3) < RND_W'(GRID_Z));

	// The clearing pass owns the write port; no item is in flight while it runs.
	assign ram_we = clr_q || (en.s4 && v_s3 && hit_s3);
	assign ram_waddr = clr_q ? clr_addr_q : mark_addr;
	assign ram_wdata = !clr_q;
	assign ram_re = en.s4 && v_s3 && (req_s3 == REQ_READ);

	voxmk_ram #(
		.WIDTH (1),
		.DEPTH (CELL_COUNT)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (read_addr),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk) begin
		if (en.s4) begin
			req_s4 <= req_s3;
			hit_s4 <= hit_s3;
			rd_ok_s4 <= rd_ok;
			if (req_s3 == REQ_READ) begin
				cx_s4 <= rx_s3;
				cy_s4 <= ry_s3;
				cz_s4 <= rz_s3;
			end else if (hit_s3) begin
				cx_s4 <= CELL_X_W'(idx_x);
				cy_s4 <= CELL_Y_W'(idx_y);
				cz_s4 <= CELL_Z_W'(idx_z);
			end else begin
				cx_s4 <= '0;
				cy_s4 <= '0;
				cz_s4 <= '0;
			end
		end
	end

	assign out_valid = v_s4;
	assign in_grid = hit_s4;
	assign cell_x = cx_s4;
	assign cell_y = cy_s4;
	assign cell_z = cz_s4;
	assign occupied = (req_s4 == REQ_READ) ? (rd_ok_s4 && ram_rdata) : hit_s4;

endmodule

// ===== sv/voxmk_ram.sv =====
// Generic single write port, single read port RAM with registered read data.
module voxmk_ram #(
	parameter int WIDTH = 1,
	parameter int DEPTH = 2
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== sv/voxmk_axis.sv =====
// One axis of the cell index datapath: box test, scaling multiply, clamp and rounding.
module voxmk_axis (
	input  logic                              clk,
	input  voxmk_pkg::pipe_en_t               en,
	input  logic [voxmk_pkg::COORD_W-1:0]     p_s1,
	input  logic [voxmk_pkg::COORD_W-1:0]     lo,
	input  logic [voxmk_pkg::COORD_W-1:0]     hi,
	input  logic [voxmk_pkg::COORD_W-1:0]     inv,
	output logic                              in_box,
	output logic [voxmk_pkg::RND_W-1:0]       rnd_s3
);
	import voxmk_pkg::*;

	logic [COORD_W-1:0] off;
	logic [COORD_W-1:0] span;
	logic [PROD_W-1:0]  prod;
	logic [PROD_W-1:0]  span_prod;
	logic [COORD_W-1:0] lim_q;
	logic [PROD_W-1:0]  prod_s2;
	logic               over;
	logic [RND_W-1:0]   rnd;

	assign in_box = ($signed(p_s1) >= $signed(lo)) && ($signed(p_s1) <= $signed(hi));

	// Inside the box both differences are non-negative and fit in 32 bits.
	assign off = p_s1 - lo;
	assign span = hi - lo;
	assign prod = PROD_W'(off) * PROD_W'(inv);
	assign span_prod = PROD_W'(span) * PROD_W'(inv);

	// The upper limit follows the configuration; settling it before items use it is left to the user.
	always_ff @(posedge clk) begin
		lim_q <= span_prod[PROD_W-1:COORD_W];
	end

	always_ff @(posedge clk) begin
		if (en.s2) begin
			prod_s2 <= prod;
		end
	end

	assign over = (prod_s2[PROD_W-1:COORD_W] > lim_q) ||
		((prod_s2[PROD_W-1:COORD_W] == lim_q) && (prod_s2[COORD_W-1:0] != '0));

	// A clamped value has a zero fraction, so rounding leaves its integer part.
	assign rnd = over ? RND_W'(lim_q) :
		RND_W'(prod_s2[PROD_W-1:COORD_W]) + RND_W'(prod_s2[COORD_W-1]);

	always_ff @(posedge clk) begin
		if (en.s3) begin
			rnd_s3 <= rnd;
		end
	end

endmodule

// ===== sv/voxmk_checker.sv =====
// Port-level checker for the voxel marker and the bind that attaches it.
module voxmk_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            in_stall,
	input logic                            out_valid,
	input logic                            out_stall,
	input logic                            in_grid,
	input logic [voxmk_pkg::CELL_X_W-1:0]  cell_x,
	input logic [voxmk_pkg::CELL_Y_W-1:0]  cell_y,
	input logic [voxmk_pkg::CELL_Z_W-1:0]  cell_z,
	input logic                            occupied
);

	// A stalled result stays offered.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result dropped while stalled");

	// A stalled result keeps its payload.
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable({in_grid, cell_x, cell_y, cell_z, occupied}))
		else $error("result payload changed while stalled");

	// A marked point always reports its cell as occupied.
	a_mark_occ: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && in_grid |-> occupied)
		else $error("marked point not reported occupied");

	// The store is being cleared right after reset, so no input transfer is taken.
	a_clear_stall: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(arst_n) |-> in_stall)
		else $error("input taken during clearing pass");

endmodule

bind point_cloud_voxel_marker voxmk_checker u_voxmk_checker (.*);

// ===== sim/testbench.sv =====
// Self-checking testbench for the point cloud voxel marker: box test, cell indexing, occupancy.
`timescale 1ns / 1ps

module testbench;

	import voxmk_pkg::*;

	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;
	localparam logic [COORD_W-1:0] Q_ONE = 32'h0001_0000;
	localparam logic [COORD_W-1:0] Q_MOST_NEG = 32'h8000_0000;
	localparam logic [COORD_W-1:0] Q_MOST_POS = 32'h7FFF_FFFF;
	localparam int CELL_W = CELL_Z_W + CELL_Y_W + CELL_X_W;

	typedef struct packed {
		logic                in_grid;
		logic [CELL_X_W-1:0] cell_x;
		logic [CELL_Y_W-1:0] cell_y;
		logic [CELL_Z_W-1:0] cell_z;
		logic                occupied;
	} voxel_reply_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [COORD_W-1:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic req_type = REQ_MARK;
	logic [COORD_W-1:0] point_x = '0;
	logic [COORD_W-1:0] point_y = '0;
	logic [COORD_W-1:0] point_z = '0;
	logic [CELL_X_W-1:0] read_x = '0;
	logic [CELL_Y_W-1:0] read_y = '0;
	logic [CELL_Z_W-1:0] read_z = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic in_grid;
	logic [CELL_X_W-1:0] cell_x;
	logic [CELL_Y_W-1:0] cell_y;
	logic [CELL_Z_W-1:0] cell_z;
	logic occupied;

	// Shadow of the box and reciprocal, index 0 is x, 1 is y, 2 is z.
	logic [COORD_W-1:0] box_lo [3];
	logic [COORD_W-1:0] box_hi [3];
	logic [COORD_W-1:0] inv_res = INV_RES_RESET;

	bit occ_map [CELL_COUNT];
	logic [CELL_W-1:0] marked_cells [$];
	voxel_reply_t voxel_reply_q [$];
	voxel_reply_t want_reply;

	int errors = 0;
	bit steady_tx = 1'b0;
	bit steady_rx = 1'b0;
	int rx_hold_left = 0;

	point_cloud_voxel_marker DUT (.*);

	always #5 clk = ~clk;

	initial begin
		#60_000_000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	// Receiver: random stalls, or a long hold-off counted down here.
	always @(negedge clk) begin
		if (rx_hold_left != 0) begin
			out_stall <= 1'b1;
			rx_hold_left <= rx_hold_left - 1;
		end else begin
			out_stall <= !steady_rx && ($urandom_range(0, 99) < 24);
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (voxel_reply_q.size() == 0) begin
				$error("result transfer with no pending prediction");
				errors++;
			end else begin
				want_reply = voxel_reply_q.pop_front();
				if (in_grid !== want_reply.in_grid) begin
					$error("in_grid expected %0d got %0d", want_reply.in_grid, in_grid);
					errors++;
				end
				if (cell_x !== want_reply.cell_x) begin
					$error("cell_x expected %0d got %0d", want_reply.cell_x, cell_x);
					errors++;
				end
				if (cell_y !== want_reply.cell_y) begin
					$error("cell_y expected %0d got %0d", want_reply.cell_y, cell_y);
					errors++;
				end
				if (cell_z !== want_reply.cell_z) begin
					$error("cell_z expected %0d got %0d", want_reply.cell_z, cell_z);
					errors++;
				end
				if (occupied !== want_reply.occupied) begin
					$error("occupied expected %0d got %0d", want_reply.occupied, occupied);
					errors++;
				end
			end
		end
	end

	function automatic bit axis_holds(logic [COORD_W-1:0] p, logic [COORD_W-1:0] lo,
		logic [COORD_W-1:0] hi);
		return $signed(p) >= $signed(lo) && $signed(p) <= $signed(hi);
	endfunction

	// Offset times reciprocal is exact in 64 bits; it is clamped to the whole cells of the
	// span, rounded half up and then limited to the last cell of the axis.
	function automatic int unsigned axis_cell_index(logic [COORD_W-1:0] p,
		logic [COORD_W-1:0] lo, logic [COORD_W-1:0] hi, int unsigned grid);
		longint unsigned offset, span, inv64, prod, lim, idx;
		offset = longint'($signed(p)) - longint'($signed(lo));
		span = longint'($signed(hi)) - longint'($signed(lo));
		inv64 = inv_res;
		prod = offset * inv64;
		lim = ((span * inv64) >> 32) << 32;
		if (prod > lim)
			prod = lim;
		idx = (prod + 64'h8000_0000) >> 32;
		if (idx > grid - 1)
			idx = grid - 1;
		return 32'(idx);
	endfunction

	function automatic int unsigned voxel_address(int unsigned x, int unsigned y,
		int unsigned z);
		return (z * GRID_Y + y) * GRID_X + x;
	endfunction

	function automatic void predict_voxel_reply(logic rq, logic [COORD_W-1:0] px,
		logic [COORD_W-1:0] py, logic [COORD_W-1:0] pz, logic [CELL_X_W-1:0] rx,
		logic [CELL_Y_W-1:0] ry, logic [CELL_Z_W-1:0] rz);
		voxel_reply_t r;
		int unsigned ix, iy, iz;
		r = '0;
		if (rq == REQ_MARK) begin
			if (axis_holds(px, box_lo[0], box_hi[0]) && axis_holds(py, box_lo[1], box_hi[1])
				&& axis_holds(pz, box_lo[2], box_hi[2])) begin
				ix = axis_cell_index(px, box_lo[0], box_hi[0], GRID_X);
				iy = axis_cell_index(py, box_lo[1], box_hi[1], GRID_Y);
				iz = axis_cell_index(pz, box_lo[2], box_hi[2], GRID_Z);
				occ_map[voxel_address(ix, iy, iz)] = 1'b1;
				r.in_grid = 1'b1;
				r.cell_x = CELL_X_W'(ix);
				r.cell_y = CELL_Y_W'(iy);
				r.cell_z = CELL_Z_W'(iz);
				r.occupied = 1'b1;
				marked_cells.insert(marked_cells.size(), {r.cell_z, r.cell_y, r.cell_x});
			end
		end else begin
			r.cell_x = rx;
			r.cell_y = ry;
			r.cell_z = rz;
			if (rx < GRID_X && ry < GRID_Y && rz < GRID_Z)
				r.occupied = occ_map[voxel_address(rx, ry, rz)];
		end
		voxel_reply_q.insert(voxel_reply_q.size(), r);
	endfunction

	// Offers one request, with a random gap in front, and holds it until the transfer.
	task automatic send_request(input logic rq, input logic [COORD_W-1:0] px,
		input logic [COORD_W-1:0] py, input logic [COORD_W-1:0] pz,
		input logic [CELL_X_W-1:0] rx, input logic [CELL_Y_W-1:0] ry,
		input logic [CELL_Z_W-1:0] rz);
		while (!steady_tx && $urandom_range(0, 99) < 24) begin
			in_valid = 1'b0;
			@(negedge clk);
		end
		in_valid = 1'b1;
		req_type = rq;
		point_x = px;
		point_y = py;
		point_z = pz;
		read_x = rx;
		read_y = ry;
		read_z = rz;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		predict_voxel_reply(rq, px, py, pz, rx, ry, rz);
		@(negedge clk);
	endtask

	task automatic mark_point(input logic [COORD_W-1:0] px, input logic [COORD_W-1:0] py,
		input logic [COORD_W-1:0] pz);
		send_request(REQ_MARK, px, py, pz, '0, '0, '0);
	endtask

	task automatic read_cell(input logic [CELL_X_W-1:0] rx, input logic [CELL_Y_W-1:0] ry,
		input logic [CELL_Z_W-1:0] rz);
		send_request(REQ_READ, '0, '0, '0, rx, ry, rz);
	endtask

	task automatic wait_idle();
		in_valid = 1'b0;
		while (voxel_reply_q.size() != 0)
			@(negedge clk);
		repeat (6) @(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [COORD_W-1:0] val);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data = val;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		case (idx)
			REG_X_MIN: box_lo[0] = val;
			REG_X_MAX: box_hi[0] = val;
			REG_Y_MIN: box_lo[1] = val;
			REG_Y_MAX: box_hi[1] = val;
			REG_Z_MIN: box_lo[2] = val;
			REG_Z_MAX: box_hi[2] = val;
			REG_INV_RES: inv_res = val;
			default: ;
		endcase
		@(negedge clk);
	endtask

	task automatic configure(input logic [COORD_W-1:0] xl, input logic [COORD_W-1:0] xh,
		input logic [COORD_W-1:0] yl, input logic [COORD_W-1:0] yh,
		input logic [COORD_W-1:0] zl, input logic [COORD_W-1:0] zh,
		input logic [COORD_W-1:0] inv);
		wait_idle();
		write_reg(REG_X_MIN, xl);
		write_reg(REG_X_MAX, xh);
		write_reg(REG_Y_MIN, yl);
		write_reg(REG_Y_MAX, yh);
		write_reg(REG_Z_MIN, zl);
		write_reg(REG_Z_MAX, zh);
		write_reg(REG_INV_RES, inv);
		cfg_valid = 1'b0;
	endtask

	// A box whose span covers roughly the grid at the chosen reciprocal, a little less
	// or more so that both partial use and saturation show up.
	task automatic pick_grid_config();
		logic [COORD_W-1:0] inv;
		logic [COORD_W-1:0] lo [3];
		logic [COORD_W-1:0] hi [3];
		longint ideal, span, base;
		int unsigned grid_of [3];
		int a;
		grid_of[0] = GRID_X;
		grid_of[1] = GRID_Y;
		grid_of[2] = GRID_Z;
		inv = $urandom_range(32'h0000_1000, 32'h0100_0000);
		for (a = 0; a < 3; a++) begin
			ideal = (longint'(grid_of[a]) << 32) / longint'(inv);
			span = ideal * $urandom_range(60, 140) / 100;
			if (span < 1)
				span = 1;
			base = longint'($urandom_range(0, 32'h7FFF_FFFF)) - 64'sd1073741824;
			lo[a] = base[31:0];
			hi[a] = 32'(base + span);
		end
		configure(lo[0], hi[0], lo[1], hi[1], lo[2], hi[2], inv);
	endtask

	// Mostly points inside the box and reads of cells already marked; noisy items are
	// fully random.
	task automatic send_random_item(input bit noisy);
		logic [COORD_W-1:0] pt [3];
		logic [CELL_X_W-1:0] rx;
		logic [CELL_Y_W-1:0] ry;
		logic [CELL_Z_W-1:0] rz;
		logic rq;
		longint d;
		int a, pick;
		rq = ($urandom_range(0, 99) < 40) ? REQ_READ : REQ_MARK;
		for (a = 0; a < 3; a++) begin
			d = longint'($signed(box_hi[a])) - longint'($signed(box_lo[a]));
			pick = $urandom_range(0, 99);
			if (noisy || d < 0 || pick < 3)
				pt[a] = $urandom();
			else if (pick < 6)
				pt[a] = box_lo[a] - 1;
			else if (pick < 9)
				pt[a] = box_hi[a] + 1;
			else if (pick < 13)
				pt[a] = box_lo[a];
			else if (pick < 17)
				pt[a] = box_hi[a];
			else
				pt[a] = box_lo[a] + $urandom_range(0, 32'(d));
		end
		if (!noisy && marked_cells.size() != 0 && $urandom_range(0, 99) < 70)
			{rz, ry, rx} = marked_cells[$urandom_range(0, marked_cells.size() - 1)];
		else
			{rz, ry, rx} = CELL_W'($urandom());
		send_request(rq, pt[0], pt[1], pt[2], rx, ry, rz);
	endtask

	// Reset box is the single point at the origin with unit reciprocal.
	task automatic test_reset_state();
		mark_point('0, '0, '0);
		mark_point(32'h0000_0001, '0, '0);
		read_cell('0, '0, '0);
		read_cell(7'd127, 7'd127, 6'd63);
	endtask

	task automatic test_unused_register();
		wait_idle();
		write_reg(REG_UNUSED, 32'hFFFF_FFFF);
		cfg_valid = 1'b0;
		mark_point('0, '0, '0);
		mark_point(32'hFFFF_FFFF, '0, '0);
	endtask

	task automatic test_extreme_bounds();
		configure(Q_MOST_NEG, Q_MOST_POS, Q_MOST_NEG, Q_MOST_POS, Q_MOST_NEG, Q_MOST_POS, '0);
		mark_point(Q_MOST_NEG, Q_MOST_NEG, Q_MOST_NEG);
		mark_point(Q_MOST_POS, Q_MOST_POS, Q_MOST_POS);
		configure(Q_MOST_NEG, Q_MOST_POS, Q_MOST_NEG, Q_MOST_POS, Q_MOST_NEG, Q_MOST_POS,
			32'hFFFF_FFFF);
		mark_point(Q_MOST_POS, Q_MOST_POS, Q_MOST_POS);
		mark_point('0, '0, '0);
		mark_point(Q_MOST_NEG, Q_MOST_NEG, Q_MOST_NEG);
		read_cell(7'd127, 7'd127, 6'd63);
		read_cell('0, '0, '0);
	endtask

	task automatic test_rounding_and_clamp();
		configure('0, 32'd100 * Q_ONE, '0, 32'd100 * Q_ONE, '0, 32'd100 * Q_ONE, Q_ONE);
		// Exactly half a cell rounds up, just below stays, and z saturates at the grid edge.
		mark_point(32'h0000_8000, 32'h0000_7FFF, 32'd100 * Q_ONE);
		mark_point(32'h0002_8000, 32'd100 * Q_ONE, 32'h0002_7FFF);
		// A span of 1.1 units at reciprocal 1.5 is 1.65 cells and holds one whole cell: the far bound is clamped there.
		configure('0, 32'h0001_199A, '0, 32'h0001_199A, '0, 32'h0001_199A, 32'h0001_8000);
		mark_point(32'h0001_199A, 32'h0001_199A, 32'h0001_199A);
		mark_point(32'h0000_5556, '0, 32'h0000_5555);
	endtask

	task automatic test_inverted_box();
		configure(32'd10 * Q_ONE, -32'd10 * Q_ONE, -32'd10 * Q_ONE, 32'd10 * Q_ONE,
			-32'd10 * Q_ONE, 32'd10 * Q_ONE, Q_ONE);
		mark_point('0, '0, '0);
		configure(-32'd10 * Q_ONE, 32'd10 * Q_ONE, -32'd10 * Q_ONE, 32'd10 * Q_ONE,
			32'd10 * Q_ONE, 32'd10 * Q_ONE - 1, Q_ONE);
		mark_point('0, '0, 32'd10 * Q_ONE);
	endtask

	task automatic test_random_grids();
		int phase, n;
		for (phase = 0; phase < 6; phase++) begin
			pick_grid_config();
			// One phase runs with neither side idling.
			steady_tx = (phase == 2);
			steady_rx = (phase == 2);
			for (n = 0; n < 100; n++)
				send_random_item(1'b0);
			steady_tx = 1'b0;
			steady_rx = 1'b0;
		end
	endtask

	task automatic test_random_noise();
		int n;
		configure($urandom(), $urandom(), $urandom(), $urandom(), $urandom(), $urandom(),
			$urandom());
		for (n = 0; n < 60; n++)
			send_random_item(1'b1);
	endtask

	// The result side holds off long enough for the pipeline to fill and stall its input.
	task automatic test_output_holdoff();
		int n;
		pick_grid_config();
		rx_hold_left = 300;
		steady_tx = 1'b1;
		for (n = 0; n < 50; n++)
			send_random_item(1'b0);
		steady_tx = 1'b0;
	endtask

	task automatic test_sender_pause();
		int n;
		pick_grid_config();
		for (n = 0; n < 20; n++)
			send_random_item(1'b0);
		in_valid = 1'b0;
		while (voxel_reply_q.size() != 0)
			@(negedge clk);
		for (n = 0; n < 20; n++)
			send_random_item(1'b0);
	endtask

	initial begin
		int guard;
		box_lo = '{default: '0};
		box_hi = '{default: '0};
		repeat (3) @(negedge clk);
		arst_n = 1'b1;
		test_reset_state();
		test_unused_register();
		test_extreme_bounds();
		test_rounding_and_clamp();
		test_inverted_box();
		test_random_grids();
		test_random_noise();
		test_output_holdoff();
		test_sender_pause();
		in_valid = 1'b0;
		guard = 0;
		while (voxel_reply_q.size() != 0 && guard < 50000) begin
			@(negedge clk);
			guard++;
		end
		repeat (10) @(negedge clk);
		if (voxel_reply_q.size() != 0) begin
			$error("%0d predicted results never arrived", voxel_reply_q.size());
			errors++;
		end
		if (errors == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
